### hdl/hrpx_pkg.sv
// ----------------------------------------------------------------------------
// hrpx_pkg: shared types and constants for the HTTP response parser
// Holds the parser phase encoding, the result status codes, the character
// constants, the header name table and the control state record.
// ----------------------------------------------------------------------------
package hrpx_pkg;

	// Default width of the Content-Length accumulator.
	localparam int DEFAULT_LENGTH_BITS = 32;

	// Number of characters in "content-length".
	localparam logic [3:0] NAME_LEN = 4'd14;

	// Characters the parser looks for.
	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UPA   = 8'h41;
	localparam logic [7:0] CH_UPZ   = 8'h5A;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CASE_OFS = 8'h20;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_MORE    = 2'd0,
		ST_DONE    = 2'd1,
		ST_ERROR   = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	// Parser phases, in stream order; the literal prefix phases are consecutive.
	typedef enum logic [4:0] {
		PH_H, PH_T1, PH_T2, PH_P, PH_SLASH, PH_ONE, PH_DOT, PH_ONE2, PH_SP,
		PH_CODE, PH_REASON, PH_LF1, PH_LINE, PH_NAME, PH_COLSP, PH_VALUE,
		PH_CONT, PH_HLF, PH_FLF, PH_BODY, PH_DONE, PH_ERR
	} phase_t;

	// Control part of the message state.
	typedef struct packed {
		phase_t      phase;
		logic [15:0] status_acc;
		logic [7:0]  chain_key;
		logic [3:0]  name_pos;
		logic        name_matches;
		logic        cur_is_len;
		logic        value_bad;
		logic        value_empty;
		logic        length_bad;
		logic        header_seen;
	} ctrl_t;

	localparam ctrl_t CTRL_RESET = '{
		phase:        PH_H,
		status_acc:   16'd0,
		chain_key:    8'd0,
		name_pos:     4'd0,
		name_matches: 1'b1,
		cur_is_len:   1'b0,
		value_bad:    1'b0,
		value_empty:  1'b0,
		length_bad:   1'b0,
		header_seen:  1'b0
	};

	// Per-byte result fields.
	typedef struct packed {
		status_t     status;
		logic        body_valid;
		logic [7:0]  body_byte;
		logic [15:0] status_value;
		logic [31:0] body_length;
		logic [7:0]  end_key;
	} result_t;

	// Expected character of the "HTTP/1.1 " prefix for a literal phase.
	function automatic logic [7:0] prefix_char(input phase_t ph);
		logic [7:0] ch;
		case (ph)
			PH_H:     ch = CH_H;
			PH_T1:    ch = CH_T;
			PH_T2:    ch = CH_T;
			PH_P:     ch = CH_P;
			PH_SLASH: ch = CH_SLASH;
			PH_ONE:   ch = CH_ONE;
			PH_DOT:   ch = CH_DOT;
			PH_ONE2:  ch = CH_ONE;
			PH_SP:    ch = CH_SP;
			default:  ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Lower-case "content-length", one character per position.
	function automatic logic [7:0] name_char_at(input logic [3:0] pos);
		logic [7:0] ch;
		case (pos)
			4'd0:    ch = 8'h63; // c
			4'd1:    ch = 8'h6F; // o
			4'd2:    ch = 8'h6E; // n
			4'd3:    ch = 8'h74; // t
			4'd4:    ch = 8'h65; // e
			4'd5:    ch = 8'h6E; // n
			4'd6:    ch = 8'h74; // t
			4'd7:    ch = 8'h2D; // -
			4'd8:    ch = 8'h6C; // l
			4'd9:    ch = 8'h65; // e
			4'd10:   ch = 8'h6E; // n
			4'd11:   ch = 8'h67; // g
			4'd12:   ch = 8'h74; // t
			4'd13:   ch = 8'h68; // h
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Token characters of a header name: printable ASCII minus separators.
	function automatic logic is_token(input logic [7:0] c);
		logic ok;
		if (c < CH_SP || c >= CH_DEL) begin
			ok = 1'b0;
		end else begin
			case (c)
				8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
				8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20:
					ok = 1'b0;
				default: ok = 1'b1;
			endcase
		end
		return ok;
	endfunction

	function automatic logic is_dec_char(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

### hdl/http_response_parser_xor_body.sv
// ----------------------------------------------------------------------------
// http_response_parser_xor_body: HTTP/1.1 response parser with XOR body decode
// Parses status line and headers of a response byte stream, extracts the
// status code and Content-Length, and decodes the chained-XOR body.
// ----------------------------------------------------------------------------
// The block takes one response byte per cycle and returns one result per byte:
// the byte is captured in an input register, one pass of next-state logic
// updates the message state, and the result lands in an output register. The
// state update loops through the state register alone, so a new byte is
// accepted in every cycle as long as the result side keeps taking results; a
// stalled result holds the input register, and input ready drops only when
// both registers are full. Setting tuser on a byte restarts the parser with
// that byte as the first of a new message. The seed key is sampled when the
// blank line ending the headers is processed.
module http_response_parser_xor_body #(
	parameter int LENGTH_BITS = hrpx_pkg::DEFAULT_LENGTH_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	// Seed key register.
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	// Input bytes.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] new_message
	// Results.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [7:0] body_byte, [23:8] status_value,
	                                    // [55:24] body_length, [63:56] end_key
	output logic [2:0]  m_axis_tuser    // [1:0] parse_status, [2] body_valid
);

	logic                   valid_s1;
	logic [7:0]             data_s1;
	logic                   newmsg_s1;
	logic                   advance;

	logic [7:0]             seed_key_q;
	hrpx_pkg::ctrl_t        ctrl_q;
	logic [LENGTH_BITS-1:0] value_q;
	logic [LENGTH_BITS-1:0] length_q;
	logic [LENGTH_BITS-1:0] remain_q;

	hrpx_pkg::ctrl_t        ctrl_d;
	logic [LENGTH_BITS-1:0] value_d;
	logic [LENGTH_BITS-1:0] length_d;
	logic [LENGTH_BITS-1:0] remain_d;
	hrpx_pkg::result_t      res_d;

	logic                   out_valid_s2;
	hrpx_pkg::result_t      res_s2;

	// The input stage moves on when the result register is free or being drained.
	assign advance       = valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// Seed key register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seed_key_q <= 8'd0;
		else if (cfg_we)
			seed_key_q <= cfg_wdata;
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_axis_tready)
			valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1   <= s_axis_tdata;
			newmsg_s1 <= s_axis_tuser;
		end
	end

	// Next-state logic for the byte in the input register.
	hrpx_next #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_next (
		.cur         (ctrl_q),
		.cur_value   (value_q),
		.cur_length  (length_q),
		.cur_remain  (remain_q),
		.seed_key    (seed_key_q),
		.data_byte   (data_s1),
		.new_message (newmsg_s1),
		.nxt         (ctrl_d),
		.nxt_value   (value_d),
		.nxt_length  (length_d),
		.nxt_remain  (remain_d),
		.res         (res_d)
	);

	// Message state, updated once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q   <= hrpx_pkg::CTRL_RESET;
			value_q  <= '0;
			length_q <= '0;
			remain_q <= '0;
		end else if (advance) begin
			ctrl_q   <= ctrl_d;
			value_q  <= value_d;
			length_q <= length_d;
			remain_q <= remain_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_s2 <= 1'b0;
		else if (!out_valid_s2 || m_axis_tready)
			out_valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_d;
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {res_s2.end_key, res_s2.body_length, res_s2.status_value,
		res_s2.body_byte};
	assign m_axis_tuser  = {res_s2.body_valid, res_s2.status};

`ifndef SYNTH
	// Input ready drops only when both stages hold an item and the result is stalled.
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_s2 && !m_axis_tready))
		else $error("input stalled while a stage is free");

	// A decoded body byte never comes with an error or ignored status.
	a_body_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res_s2.body_valid) |->
		(res_s2.status == hrpx_pkg::ST_MORE || res_s2.status == hrpx_pkg::ST_DONE))
		else $error("body byte with bad status");

	// While in the body, at least one byte is still due.
	a_body_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl_q.phase == hrpx_pkg::PH_BODY) |-> (remain_q != '0))
		else $error("body phase with no bytes remaining");
`endif

endmodule

### hdl/hrpx_next.sv
// ----------------------------------------------------------------------------
// hrpx_next: next-state and result logic of the response parser
// Given the current message state and one input byte, computes the state
// after that byte and the result fields it produces. Purely combinational.
// ----------------------------------------------------------------------------
module hrpx_next #(
	parameter int LENGTH_BITS = hrpx_pkg::DEFAULT_LENGTH_BITS
) (
	input  hrpx_pkg::ctrl_t         cur,
	input  logic [LENGTH_BITS-1:0]  cur_value,
	input  logic [LENGTH_BITS-1:0]  cur_length,
	input  logic [LENGTH_BITS-1:0]  cur_remain,
	input  logic [7:0]              seed_key,
	input  logic [7:0]              data_byte,
	input  logic                    new_message,
	output hrpx_pkg::ctrl_t         nxt,
	output logic [LENGTH_BITS-1:0]  nxt_value,
	output logic [LENGTH_BITS-1:0]  nxt_length,
	output logic [LENGTH_BITS-1:0]  nxt_remain,
	output hrpx_pkg::result_t       res
);

	hrpx_pkg::ctrl_t        c;
	logic [LENGTH_BITS-1:0] value_c;
	logic [LENGTH_BITS-1:0] length_c;
	logic [LENGTH_BITS-1:0] remain_c;

	logic [7:0]             lc;
	logic                   name_hit;
	logic [19:0]            status_x10;
	logic [LENGTH_BITS+3:0] value_x10;
	logic                   value_ovf;
	logic [LENGTH_BITS-1:0] commit_length;
	logic                   commit_bad;
	logic [LENGTH_BITS-1:0] remain_dec;
	logic [LENGTH_BITS+31:0] length_ext;
	hrpx_pkg::status_t      st;

	// A new message starts from the cleared state.
	always_comb begin
		if (new_message) begin
			c        = hrpx_pkg::CTRL_RESET;
			value_c  = '0;
			length_c = '0;
			remain_c = '0;
		end else begin
			c        = cur;
			value_c  = cur_value;
			length_c = cur_length;
			remain_c = cur_remain;
		end
	end

	// Case-folded name character and its match against the table.
	assign lc = (data_byte >= hrpx_pkg::CH_UPA && data_byte <= hrpx_pkg::CH_UPZ) ?
		data_byte + hrpx_pkg::CASE_OFS : data_byte;
	assign name_hit = (c.name_pos < hrpx_pkg::NAME_LEN) &&
		(lc == hrpx_pkg::name_char_at(c.name_pos));

	// Decimal accumulators: times ten by shift and add, plus the digit.
	assign status_x10 = ({4'd0, c.status_acc} << 3) + ({4'd0, c.status_acc} << 1) +
		{16'd0, data_byte[3:0]};
	assign value_x10 = ({4'd0, value_c} << 3) + ({4'd0, value_c} << 1) +
		{{LENGTH_BITS{1'b0}}, data_byte[3:0]};
	assign value_ovf = |value_x10[LENGTH_BITS+3:LENGTH_BITS];

	// Closing the previous header line.
	assign commit_length = c.cur_is_len ? value_c : length_c;
	assign commit_bad = c.length_bad | (c.cur_is_len & (c.value_bad | c.value_empty));

	assign remain_dec = remain_c - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

	// One state transition per byte.
	always_comb begin
		nxt        = c;
		nxt_value  = value_c;
		nxt_length = length_c;
		nxt_remain = remain_c;
		st         = hrpx_pkg::ST_MORE;
		res.body_valid = 1'b0;
		res.body_byte  = 8'd0;
		res.end_key    = 8'd0;

		case (c.phase)
			hrpx_pkg::PH_H, hrpx_pkg::PH_T1, hrpx_pkg::PH_T2, hrpx_pkg::PH_P,
			hrpx_pkg::PH_SLASH, hrpx_pkg::PH_ONE, hrpx_pkg::PH_DOT,
			hrpx_pkg::PH_ONE2, hrpx_pkg::PH_SP: begin
				if (data_byte == hrpx_pkg::prefix_char(c.phase))
					nxt.phase = hrpx_pkg::phase_t'(c.phase + 5'd1);
				else
					nxt.phase = hrpx_pkg::PH_ERR;
			end
			hrpx_pkg::PH_CODE: begin
				if (hrpx_pkg::is_dec_char(data_byte)) begin
					nxt.status_acc = (|status_x10[19:16]) ? 16'hFFFF : status_x10[15:0];
				end else if (data_byte == hrpx_pkg::CH_SP) begin
					nxt.phase = hrpx_pkg::PH_REASON;
				end else begin
					nxt.phase = hrpx_pkg::PH_ERR;
				end
			end
			hrpx_pkg::PH_REASON: begin
				if (data_byte == hrpx_pkg::CH_CR)
					nxt.phase = hrpx_pkg::PH_LF1;
			end
			hrpx_pkg::PH_LF1, hrpx_pkg::PH_HLF: begin
				nxt.phase = (data_byte == hrpx_pkg::CH_LF) ? hrpx_pkg::PH_LINE :
					hrpx_pkg::PH_ERR;
			end
			hrpx_pkg::PH_LINE: begin
				if (hrpx_pkg::is_token(data_byte)) begin
					nxt_length       = commit_length;
					nxt.length_bad   = commit_bad;
					nxt.cur_is_len   = 1'b0;
					nxt.header_seen  = 1'b1;
					nxt.name_pos     = (lc == hrpx_pkg::name_char_at(4'd0)) ? 4'd1 : 4'd0;
					nxt.name_matches = (lc == hrpx_pkg::name_char_at(4'd0));
					nxt.phase        = hrpx_pkg::PH_NAME;
				end else if (data_byte == hrpx_pkg::CH_SP || data_byte == hrpx_pkg::CH_TAB) begin
					nxt.phase = c.header_seen ? hrpx_pkg::PH_CONT : hrpx_pkg::PH_ERR;
				end else if (data_byte == hrpx_pkg::CH_CR) begin
					nxt_length     = commit_length;
					nxt.length_bad = commit_bad;
					nxt.cur_is_len = 1'b0;
					nxt.phase      = commit_bad ? hrpx_pkg::PH_ERR : hrpx_pkg::PH_FLF;
				end else begin
					nxt.phase = hrpx_pkg::PH_ERR;
				end
			end
			hrpx_pkg::PH_NAME: begin
				if (hrpx_pkg::is_token(data_byte)) begin
					if (name_hit)
						nxt.name_pos = c.name_pos + 4'd1;
					else
						nxt.name_matches = 1'b0;
				end else if (data_byte == hrpx_pkg::CH_COLON) begin
					nxt.cur_is_len  = c.name_matches && (c.name_pos == hrpx_pkg::NAME_LEN);
					nxt_value       = '0;
					nxt.value_bad   = 1'b0;
					nxt.value_empty = 1'b1;
					nxt.phase       = hrpx_pkg::PH_COLSP;
				end else begin
					nxt.phase = hrpx_pkg::PH_ERR;
				end
			end
			hrpx_pkg::PH_COLSP: begin
				nxt.phase = (data_byte == hrpx_pkg::CH_SP) ? hrpx_pkg::PH_VALUE :
					hrpx_pkg::PH_ERR;
			end
			hrpx_pkg::PH_CONT, hrpx_pkg::PH_VALUE: begin
				if (c.phase == hrpx_pkg::PH_CONT &&
					(data_byte == hrpx_pkg::CH_SP || data_byte == hrpx_pkg::CH_TAB)) begin
					// Leading whitespace of a continuation line is skipped.
					nxt.phase = hrpx_pkg::PH_CONT;
				end else if (data_byte == hrpx_pkg::CH_CR) begin
					nxt.phase = hrpx_pkg::PH_HLF;
				end else begin
					nxt.phase = hrpx_pkg::PH_VALUE;
					if (hrpx_pkg::is_dec_char(data_byte)) begin
						nxt.value_empty = 1'b0;
						if (value_ovf)
							nxt.value_bad = 1'b1;
						else
							nxt_value = value_x10[LENGTH_BITS-1:0];
					end else begin
						nxt.value_bad = 1'b1;
					end
				end
			end
			hrpx_pkg::PH_FLF: begin
				if (data_byte != hrpx_pkg::CH_LF) begin
					nxt.phase = hrpx_pkg::PH_ERR;
				end else begin
					nxt.chain_key = seed_key;
					nxt_remain    = length_c;
					if (length_c == '0) begin
						st          = hrpx_pkg::ST_DONE;
						res.end_key = seed_key;
						nxt.phase   = hrpx_pkg::PH_DONE;
					end else begin
						nxt.phase = hrpx_pkg::PH_BODY;
					end
				end
			end
			hrpx_pkg::PH_BODY: begin
				// Chained XOR: the key for the next byte is this ciphertext byte.
				res.body_valid = 1'b1;
				res.body_byte  = data_byte ^ c.chain_key;
				nxt.chain_key  = data_byte;
				nxt_remain     = remain_dec;
				if (remain_dec == '0) begin
					st          = hrpx_pkg::ST_DONE;
					res.end_key = data_byte;
					nxt.phase   = hrpx_pkg::PH_DONE;
				end
			end
			default: begin
				st = hrpx_pkg::ST_IGNORED;
			end
		endcase

		if (nxt.phase == hrpx_pkg::PH_ERR && st != hrpx_pkg::ST_IGNORED)
			st = hrpx_pkg::ST_ERROR;
	end

	// Length is reported only once the headers are through.
	assign length_ext = {32'd0, nxt_length};

	assign res.status       = st;
	assign res.status_value = nxt.status_acc;
	assign res.body_length  = (nxt.phase == hrpx_pkg::PH_BODY ||
		nxt.phase == hrpx_pkg::PH_DONE) ? length_ext[31:0] : 32'd0;

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the HTTP response parser with XOR body
// Feeds response bytes through the input stream, predicts the per-byte result
// (parse status, decoded body byte, status code, Content-Length, end key) and
// checks every result taken from the output stream against the prediction.
// A short table of hand-picked bytes comes first, then generated responses
// under several seed keys, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          STALL_LIMIT = 1000;
	localparam int          HOLD_CYCLES = 80;
	localparam int          PHASE_ITEMS = 200;
	localparam logic [63:0] LEN_LIMIT   = (64'd1 << hrpx_pkg::DEFAULT_LENGTH_BITS) - 64'd1;
	localparam logic [7:0]  DIR_SEED    = 8'hFF;

	// One row of the directed table; want is used only when known is set.
	typedef struct packed {
		logic [7:0]        b;
		logic              nm;
		logic              known;
		hrpx_pkg::result_t want;
	} stim_row_t;

	localparam hrpx_pkg::result_t RES_NONE =
		'{hrpx_pkg::ST_MORE, 1'b0, 8'h00, 16'h0000, 32'h0, 8'h00};
	localparam hrpx_pkg::result_t RES_ERR0 =
		'{hrpx_pkg::ST_ERROR, 1'b0, 8'h00, 16'h0000, 32'h0, 8'h00};
	localparam hrpx_pkg::result_t RES_IGN0 =
		'{hrpx_pkg::ST_IGNORED, 1'b0, 8'h00, 16'h0000, 32'h0, 8'h00};
	localparam hrpx_pkg::result_t RES_END0 =
		'{hrpx_pkg::ST_DONE, 1'b0, 8'h00, 16'h0000, 32'h0, DIR_SEED};

	// Bad first byte, ignored bytes, a bare response with no status digits
	// and no headers, and a restart in the middle of the prefix.
	localparam stim_row_t STIM_TAB [22] = '{
		'{8'h78,              1'b1, 1'b1, RES_ERR0},
		'{8'hFF,              1'b0, 1'b1, RES_IGN0},
		'{8'h00,              1'b0, 1'b1, RES_IGN0},
		'{hrpx_pkg::CH_H,     1'b1, 1'b0, RES_NONE},
		'{hrpx_pkg::CH_T,     1'b0, 1'b0, RES_NONE},
		'{hrpx_pkg::CH_T,     1'b0, 1'b0, RES_NONE},
		'{hrpx_pkg::CH_P,     1'b0, 1'b0, RES_NONE},
		'{hrpx_pkg::CH_SLASH, 1'b0, 1'b0, RES_NONE},
		'{hrpx_pkg::CH_ONE,   1'b0, 1'b0, RES_NONE},
		'{hrpx_pkg::CH_DOT,   1'b0, 1'b0, RES_NONE},
		'{hrpx_pkg::CH_ONE,   1'b0, 1'b0, RES_NONE},
		'{hrpx_pkg::CH_SP,    1'b0, 1'b0, RES_NONE},
		'{hrpx_pkg::CH_SP,    1'b0, 1'b0, RES_NONE},
		'{hrpx_pkg::CH_CR,    1'b0, 1'b0, RES_NONE},
		'{hrpx_pkg::CH_LF,    1'b0, 1'b0, RES_NONE},
		'{hrpx_pkg::CH_CR,    1'b0, 1'b0, RES_NONE},
		'{hrpx_pkg::CH_LF,    1'b0, 1'b1, RES_END0},
		'{8'h80,              1'b0, 1'b1, RES_IGN0},
		'{hrpx_pkg::CH_H,     1'b1, 1'b0, RES_NONE},
		'{hrpx_pkg::CH_T,     1'b0, 1'b0, RES_NONE},
		'{hrpx_pkg::CH_H,     1'b1, 1'b0, RES_NONE},
		'{8'h58,              1'b0, 1'b1, RES_ERR0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] data_byte
	logic        s_axis_tuser;   // [0] new_message
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;   // [7:0] body_byte, [23:8] status_value,
	                             // [55:24] body_length, [63:56] end_key
	logic [2:0]  m_axis_tuser;   // [1:0] parse_status, [2] body_valid

	// Directed expectation travelling with the request being offered.
	logic              stim_known;
	hrpx_pkg::result_t stim_want;

	hrpx_pkg::result_t want_results [$];
	logic [8:0]  msg_q [$];
	int          in_count = 0;
	int          sent = 0;
	int          fails = 0;
	int          hold_req = 0;
	bit          idle_on = 1'b1;

	// Parser state as the bench sees it.
	logic [7:0]       seed_copy = 8'h00;
	hrpx_pkg::phase_t ph;
	logic [15:0] status_acc;
	logic [63:0] length_q;
	logic [63:0] body_cnt;
	logic [7:0]  chain;
	logic [3:0]  name_pos;
	logic        name_ok;
	logic        cur_len;
	logic [63:0] val_acc;
	logic        val_bad;
	logic        val_empty;
	logic        len_bad;
	logic        hdr_seen;

	string prefix_txt = "HTTP/1.1 ";
	string name_txt   = "content-length";
	string sep_txt    = "()<>@,;:\\\"/[]?={} ";

	http_response_parser_xor_body dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Header name characters: printable ASCII except the separators.
	function automatic bit tok_char(input logic [7:0] c);
		if (c <= 8'd31 || c >= hrpx_pkg::CH_DEL) return 1'b0;
		for (int i = 0; i < sep_txt.len(); i++) begin
			if (c == sep_txt[i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic bit digit(input logic [7:0] c);
		return c >= hrpx_pkg::CH_ZERO && c <= hrpx_pkg::CH_NINE;
	endfunction

	function automatic void clear_msg();
		ph = hrpx_pkg::PH_H;
		status_acc = '0;
		length_q = '0;
		body_cnt = '0;
		chain = '0;
		name_pos = '0;
		name_ok = 1'b1;
		cur_len = 1'b0;
		val_acc = '0;
		val_bad = 1'b0;
		val_empty = 1'b0;
		len_bad = 1'b0;
		hdr_seen = 1'b0;
	endfunction

	// A finished header line hands its value over if it was Content-Length.
	function automatic void close_header();
		if (cur_len) begin
			length_q = val_acc;
			if (val_bad || val_empty) len_bad = 1'b1;
		end
		cur_len = 1'b0;
	endfunction

	function automatic void match_name(input logic [7:0] c);
		logic [7:0] lc;
		lc = (c >= hrpx_pkg::CH_UPA && c <= hrpx_pkg::CH_UPZ) ? c + hrpx_pkg::CASE_OFS : c;
		if (name_pos < hrpx_pkg::NAME_LEN && lc == name_txt[name_pos]) name_pos++;
		else name_ok = 1'b0;
	endfunction

	function automatic void length_digit(input logic [7:0] c);
		logic [63:0] d;
		if (digit(c)) begin
			d = 64'(c - hrpx_pkg::CH_ZERO);
			if (val_acc > (LEN_LIMIT - d) / 64'd10) val_bad = 1'b1;
			else val_acc = val_acc * 64'd10 + d;
			val_empty = 1'b0;
		end else begin
			val_bad = 1'b1;
		end
	endfunction

	// Advances the bench's parser state by one byte and returns its result.
	function automatic hrpx_pkg::result_t parse_byte(input logic [7:0] c,
			input logic restart);
		hrpx_pkg::result_t r;
		logic [31:0]       code_v;
		r = RES_NONE;
		if (restart) clear_msg();
		case (ph)
			hrpx_pkg::PH_H, hrpx_pkg::PH_T1, hrpx_pkg::PH_T2, hrpx_pkg::PH_P,
			hrpx_pkg::PH_SLASH, hrpx_pkg::PH_ONE, hrpx_pkg::PH_DOT, hrpx_pkg::PH_ONE2,
			hrpx_pkg::PH_SP: begin
				if (c == prefix_txt[int'(ph)]) ph = hrpx_pkg::phase_t'(ph + 5'd1);
				else ph = hrpx_pkg::PH_ERR;
			end
			hrpx_pkg::PH_CODE: begin
				if (digit(c)) begin
					code_v = status_acc * 32'd10 + 32'(c - hrpx_pkg::CH_ZERO);
					status_acc = (code_v > 32'd65535) ? 16'hFFFF : code_v[15:0];
				end else if (c == hrpx_pkg::CH_SP) begin
					ph = hrpx_pkg::PH_REASON;
				end else begin
					ph = hrpx_pkg::PH_ERR;
				end
			end
			hrpx_pkg::PH_REASON: begin
				if (c == hrpx_pkg::CH_CR) ph = hrpx_pkg::PH_LF1;
			end
			hrpx_pkg::PH_LF1, hrpx_pkg::PH_HLF: begin
				ph = (c == hrpx_pkg::CH_LF) ? hrpx_pkg::PH_LINE : hrpx_pkg::PH_ERR;
			end
			hrpx_pkg::PH_LINE: begin
				if (tok_char(c)) begin
					close_header();
					hdr_seen = 1'b1;
					name_pos = '0;
					name_ok = 1'b1;
					match_name(c);
					ph = hrpx_pkg::PH_NAME;
				end else if (c == hrpx_pkg::CH_SP || c == hrpx_pkg::CH_TAB) begin
					ph = hdr_seen ? hrpx_pkg::PH_CONT : hrpx_pkg::PH_ERR;
				end else if (c == hrpx_pkg::CH_CR) begin
					close_header();
					ph = len_bad ? hrpx_pkg::PH_ERR : hrpx_pkg::PH_FLF;
				end else begin
					ph = hrpx_pkg::PH_ERR;
				end
			end
			hrpx_pkg::PH_NAME: begin
				if (tok_char(c)) begin
					match_name(c);
				end else if (c == hrpx_pkg::CH_COLON) begin
					cur_len = name_ok && name_pos == hrpx_pkg::NAME_LEN;
					val_acc = '0;
					val_bad = 1'b0;
					val_empty = 1'b1;
					ph = hrpx_pkg::PH_COLSP;
				end else begin
					ph = hrpx_pkg::PH_ERR;
				end
			end
			hrpx_pkg::PH_COLSP: begin
				ph = (c == hrpx_pkg::CH_SP) ? hrpx_pkg::PH_VALUE : hrpx_pkg::PH_ERR;
			end
			hrpx_pkg::PH_CONT: begin
				if (c == hrpx_pkg::CH_CR) begin
					ph = hrpx_pkg::PH_HLF;
				end else if (c != hrpx_pkg::CH_SP && c != hrpx_pkg::CH_TAB) begin
					length_digit(c);
					ph = hrpx_pkg::PH_VALUE;
				end
			end
			hrpx_pkg::PH_VALUE: begin
				if (c == hrpx_pkg::CH_CR) ph = hrpx_pkg::PH_HLF;
				else length_digit(c);
			end
			hrpx_pkg::PH_FLF: begin
				if (c != hrpx_pkg::CH_LF) begin
					ph = hrpx_pkg::PH_ERR;
				end else begin
					chain = seed_copy;
					body_cnt = '0;
					if (length_q == 64'd0) begin
						r.status = hrpx_pkg::ST_DONE;
						r.end_key = chain;
						ph = hrpx_pkg::PH_DONE;
					end else begin
						ph = hrpx_pkg::PH_BODY;
					end
				end
			end
			hrpx_pkg::PH_BODY: begin
				r.body_valid = 1'b1;
				r.body_byte = c ^ chain;
				chain = c;
				body_cnt++;
				if (body_cnt >= length_q) begin
					r.status = hrpx_pkg::ST_DONE;
					r.end_key = chain;
					ph = hrpx_pkg::PH_DONE;
				end
			end
			default: r.status = hrpx_pkg::ST_IGNORED;
		endcase
		if (ph == hrpx_pkg::PH_ERR && r.status != hrpx_pkg::ST_IGNORED)
			r.status = hrpx_pkg::ST_ERROR;
		r.status_value = status_acc;
		r.body_length = (ph == hrpx_pkg::PH_BODY || ph == hrpx_pkg::PH_DONE) ?
			length_q[31:0] : 32'h0;
		return r;
	endfunction

	// Seed writes and accepted requests update the prediction at the clock edge.
	always @(posedge clk) begin : in_side
		hrpx_pkg::result_t res;
		if (arst_n) begin
			if (cfg_we) seed_copy = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) begin
				res = parse_byte(s_axis_tdata, s_axis_tuser);
				want_results.insert(want_results.size(), stim_known ? stim_want : res);
				in_count++;
			end
		end
	end

	task automatic report_miss(input string what, input hrpx_pkg::result_t want,
			input hrpx_pkg::result_t got);
		fails++;
		if (fails <= 10) begin
			$display("%t %s: want st=%0d bv=%0b bb=%02h sv=%0d len=%0d ek=%02h", $realtime,
				what, want.status, want.body_valid, want.body_byte, want.status_value,
				want.body_length, want.end_key);
			$display("    got st=%0d bv=%0b bb=%02h sv=%0d len=%0d ek=%02h", got.status,
				got.body_valid, got.body_byte, got.status_value, got.body_length,
				got.end_key);
		end
	endtask

	// Each result taken is held against the oldest outstanding prediction.
	always @(posedge clk) begin : out_side
		hrpx_pkg::result_t got;
		hrpx_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status       = hrpx_pkg::status_t'(m_axis_tuser[1:0]);
			got.body_valid   = m_axis_tuser[2];
			got.body_byte    = m_axis_tdata[7:0];
			got.status_value = m_axis_tdata[23:8];
			got.body_length  = m_axis_tdata[55:24];
			got.end_key      = m_axis_tdata[63:56];
			if (want_results.size() == 0) begin
				report_miss("unexpected result", RES_NONE, got);
			end else begin
				want = want_results.pop_front();
				if (got.status !== want.status || got.body_valid !== want.body_valid ||
						got.body_byte !== want.body_byte ||
						got.status_value !== want.status_value ||
						got.body_length !== want.body_length ||
						got.end_key !== want.end_key) begin
					report_miss("result mismatch", want, got);
				end
			end
		end
	end

	function automatic int pick_gap();
		return ($urandom_range(0, 99) < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
	endfunction

	// Result side: random stalls, plus one long hold-off when asked for.
	initial begin : rx_side
		int stall;
		stall = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				stall = hold_req;
				hold_req = 0;
			end
			if (!arst_n) begin
				m_axis_tready <= 1'b0;
			end else if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else if (!idle_on || $urandom_range(0, 3) != 0) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				stall = pick_gap() - 1;
			end
		end
	end

	// Ends the run when nothing moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Offers one request and returns at the falling edge after it is taken.
	task automatic send_byte(input logic [7:0] b, input logic nm, input logic known,
			input hrpx_pkg::result_t want);
		int gap;
		int seen;
		gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= nm;
		stim_known <= known;
		stim_want <= want;
		seen = in_count;
		do @(negedge clk); while (in_count == seen);
		sent++;
	endtask

	// Stops offering and waits for every outstanding result.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (want_results.size() != 0);
	endtask

	task automatic load_seed(input logic [7:0] v);
		settle();
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic void put(input logic [7:0] b);
		msg_q.insert(msg_q.size(), {1'b0, b});
	endfunction

	function automatic void put_str(input string s);
		for (int i = 0; i < s.len(); i++) put(s[i]);
	endfunction

	function automatic logic [7:0] rand_tok();
		logic [7:0] c;
		do c = 8'($urandom_range(33, 126)); while (!tok_char(c));
		return c;
	endfunction

	function automatic logic [7:0] rand_text();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == hrpx_pkg::CH_CR);
		return c;
	endfunction

	function automatic void put_ws();
		repeat ($urandom_range(1, 2))
			put($urandom_range(0, 1) ? hrpx_pkg::CH_SP : hrpx_pkg::CH_TAB);
	endfunction

	function automatic void put_crlf();
		put(hrpx_pkg::CH_CR);
		put(hrpx_pkg::CH_LF);
	endfunction

	// Builds one response: mostly well formed with random content, sometimes
	// noise, a corrupted byte, a restart in the middle, or trailing bytes.
	task automatic build_message();
		int          n;
		int          k;
		int          vk;
		logic [63:0] len_val;
		logic [7:0]  ch;
		string       s;
		msg_q.delete();
		len_val = 64'd0;
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 12)) put(8'($urandom_range(0, 255)));
		end else begin
			put_str(prefix_txt);
			// Status code: none, ordinary, or around the saturation point.
			k = $urandom_range(0, 9);
			if (k == 1) s = $sformatf("%0d", $urandom_range(65530, 65540));
			else if (k == 2) s = "9999999";
			else if (k > 2) s = $sformatf("%0d", $urandom_range(100, 599));
			else s = "";
			put_str(s);
			put(hrpx_pkg::CH_SP);
			repeat ($urandom_range(0, 8)) put(rand_text());
			put_crlf();
			// A continuation line before any header is an error.
			if ($urandom_range(0, 19) == 0) begin
				put(hrpx_pkg::CH_SP);
				put(rand_tok());
				put_crlf();
			end
			repeat ($urandom_range(0, 3)) begin
				k = $urandom_range(0, 9);
				if (k < 4) begin
					for (int i = 0; i < name_txt.len(); i++) begin
						ch = name_txt[i];
						if (ch >= hrpx_pkg::CH_UPA + hrpx_pkg::CASE_OFS && $urandom_range(0, 1))
							ch -= hrpx_pkg::CASE_OFS;
						put(ch);
					end
					vk = $urandom_range(0, 19);
					case (vk)
						0: s = "";
						1: s = {$sformatf("%0d", $urandom_range(0, 9)), string'(rand_text())};
						2: s = "4294967296";
						3: s = "4294967295";
						4: s = {"00", $sformatf("%0d", $urandom_range(0, 24))};
						default: s = $sformatf("%0d", $urandom_range(0, 24));
					endcase
					if (vk > 2) len_val = 64'(s.atoi());
					put(hrpx_pkg::CH_COLON);
					put(hrpx_pkg::CH_SP);
					// The digits may be split over a continuation line.
					if (s.len() > 0 && $urandom_range(0, 3) == 0) begin
						n = $urandom_range(0, s.len());
						put_str(s.substr(0, n - 1));
						put_crlf();
						put_ws();
						put_str(s.substr(n, s.len() - 1));
					end else begin
						put_str(s);
					end
				end else begin
					if (k < 6) begin
						// Names that differ from Content-Length only in length.
						n = $urandom_range(0, 12);
						put_str(($urandom_range(0, 1)) ? {name_txt, string'(rand_tok())}
							: name_txt.substr(0, n));
					end else begin
						repeat ($urandom_range(1, 8)) put(rand_tok());
					end
					put(hrpx_pkg::CH_COLON);
					put(hrpx_pkg::CH_SP);
					repeat ($urandom_range(0, 6)) put(rand_text());
					if ($urandom_range(0, 4) == 0) begin
						put_crlf();
						put_ws();
						repeat ($urandom_range(0, 4)) put(rand_text());
					end
				end
				put_crlf();
			end
			put_crlf();
			n = (len_val <= 64'd24) ? int'(len_val) : $urandom_range(1, 6);
			repeat (n) put(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 2)) put(8'($urandom_range(0, 255)));
		end
		if (msg_q.size() > 1 && $urandom_range(0, 9) == 0) begin
			k = $urandom_range(1, msg_q.size() - 1);
			msg_q[k][7:0] = 8'($urandom_range(0, 255));
		end
		if (msg_q.size() > 1 && $urandom_range(0, 19) == 0) begin
			msg_q[$urandom_range(1, msg_q.size() - 1)][8] = 1'b1;
		end
		msg_q[0][8] = 1'b1;
	endtask

	// Stimulus: reset, directed table, then generated responses per seed key.
	initial begin : stim
		int         target;
		bit         hold_done;
		logic [7:0] seed;
		hold_done = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'h00;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		s_axis_tuser = 1'b0;
		stim_known = 1'b0;
		stim_want = RES_NONE;
		clear_msg();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		load_seed(DIR_SEED);
		for (int i = 0; i < $size(STIM_TAB); i++) begin
			send_byte(STIM_TAB[i].b, STIM_TAB[i].nm, STIM_TAB[i].known, STIM_TAB[i].want);
		end

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: seed = 8'h00;
				1: seed = 8'hFF;
				default: seed = 8'($urandom_range(0, 255));
			endcase
			load_seed(seed);
			target = sent + PHASE_ITEMS;
			while (sent < target) begin
				build_message();
				idle_on = ($urandom_range(0, 3) != 0);
				// Once, the result side stops long enough for the input to back up.
				if (p == 1 && !hold_done) begin
					hold_req = HOLD_CYCLES;
					hold_done = 1'b1;
				end
				foreach (msg_q[i]) send_byte(msg_q[i][7:0], msg_q[i][8], 1'b0, RES_NONE);
				if ($urandom_range(0, 9) == 0) settle();
			end
		end

		settle();
		repeat (8) @(negedge clk);
		if (fails == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
